// ===== hdl/prs_pkg.sv =====
// prs_pkg: shared types, constants and the record key comparator of the
// priority record sorter. No dependencies.
package prs_pkg;

  localparam int unsigned MaxEntriesDefault = 16;

  typedef struct packed {
    logic signed [7:0] strength;
    logic [2:0]        threat;
    logic [31:0]       seen;
  } key_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_FETCH,
    S_SHOW
  } prs_state_e;

  // true when stored record a stays ahead of new record b
  function automatic logic stays_ahead(key_t a, key_t b);
    logic res;
    if (a.strength != b.strength) begin
      res = (a.strength > b.strength);
    end else if (a.threat != b.threat) begin
      res = (a.threat > b.threat);
    end else begin
      res = (a.seen <= b.seen);
    end
    return res;
  endfunction

endpackage

// ===== hdl/prs_in_if.sv =====
// prs_in_if: valid/ready channel that carries one input record request.
// Used by the priority record sorter; no dependencies.
interface prs_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] signal_strength;
  logic [2:0]        threat;
  logic [31:0]       seen_time;
  logic [31:0]       record_tag;
  logic              final_entry;

  modport source (
    output valid, signal_strength, threat, seen_time, record_tag, final_entry,
    input  ready
  );
  modport sink (
    input  valid, signal_strength, threat, seen_time, record_tag, final_entry,
    output ready
  );
endinterface

// ===== hdl/prs_out_if.sv =====
// prs_out_if: valid/ready channel that carries one sorted result request.
// Used by the priority record sorter; no dependencies.
interface prs_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] out_strength;
  logic [2:0]        out_threat;
  logic [31:0]       out_seen_time;
  logic [31:0]       out_tag;
  logic              run_end;
  logic              overflowed;

  modport source (
    output valid, out_strength, out_threat, out_seen_time, out_tag, run_end, overflowed,
    input  ready
  );
  modport sink (
    input  valid, out_strength, out_threat, out_seen_time, out_tag, run_end, overflowed,
    output ready
  );
endinterface

// ===== hdl/priority_record_sorter.sv =====
// priority_record_sorter: top level, insertion sorter over a record memory.
// Depends on prs_pkg, prs_in_if and prs_out_if.
//
// Records are stored in a MAX_ENTRIES deep memory kept in order of strength
// descending, threat descending, seen time ascending; full ties keep arrival
// order. Each accepted record walks down the list from the tail with one key
// comparator and one memory read port: each stored entry that it passes is
// compared and shifted down one place, the entry it stops behind (if any) is
// compared, and then the record is written into the gap; an empty list goes
// straight to the write. Ready is low during that walk. A record that arrives
// while the list is full is dropped and flags the run as overflowed. After
// the record marked final, a fetch state follows and then the sorted list
// goes out at one result per cycle while the sink is ready, the last one
// with run_end set; ready returns in the cycle after the last result is
// taken, with an empty list.
module priority_record_sorter #(
  parameter int unsigned MAX_ENTRIES = prs_pkg::MaxEntriesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prs_in_if.sink    rec_i,
  prs_out_if.source res_o
);
  import prs_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  key_t        key_mem [MAX_ENTRIES];
  logic [31:0] tag_mem [MAX_ENTRIES];

  prs_state_e  state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          final_q, final_d;
  key_t          new_key_q, new_key_d;
  logic [31:0]   new_tag_q, new_tag_d;

  key_t          rd_key_q;
  logic [31:0]   rd_tag_q;
  logic [IW-1:0] rd_addr;

  logic          we;
  logic [IW-1:0] wa;
  key_t          wkey;
  logic [31:0]   wtag;

  logic [CW-1:0] fill_m1;
  logic          is_last;
  logic          ahead;
  logic          in_acc;
  logic          out_acc;
  key_t          in_key;

  assign fill_m1 = fill_q - CW'(1);
  assign is_last = ((CW'(idx_q) + CW'(1)) == fill_q);
  assign ahead   = stays_ahead(rd_key_q, new_key_q);
  assign in_acc  = rec_i.valid && rec_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  assign in_key.strength = rec_i.signal_strength;
  assign in_key.threat   = rec_i.threat;
  assign in_key.seen     = rec_i.seen_time;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa] <= wkey;
      tag_mem[wa] <= wtag;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_key_q <= new_key_d;
    new_tag_q <= new_tag_d;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    final_d   = final_q;
    new_key_d = new_key_q;
    new_tag_d = new_tag_q;
    rd_addr   = idx_q;
    we        = 1'b0;
    wa        = pos_q;
    wkey      = rd_key_q;
    wtag      = rd_tag_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          new_key_d = in_key;
          new_tag_d = rec_i.record_tag;
          final_d   = rec_i.final_entry;
          if (fill_q >= CW'(MAX_ENTRIES)) begin
            // list full: drop the record, still obey the final marker
            ovf_d   = 1'b1;
            state_d = rec_i.final_entry ? S_FETCH : S_IDLE;
          end else if (fill_q == '0) begin
            pos_d   = '0;
            state_d = S_PLACE;
          end else begin
            pos_d   = fill_q[IW-1:0];
            rd_addr = fill_m1[IW-1:0];
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        // rd_key_q holds the entry just above pos_q
        if (ahead) begin
          state_d = S_PLACE;
        end else begin
          we    = 1'b1;
          wa    = pos_q;
          pos_d = pos_q - IW'(1);
          if (pos_q == IW'(1)) begin
            state_d = S_PLACE;
          end else begin
            rd_addr = pos_q - IW'(2);
          end
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        wa      = pos_q;
        wkey    = new_key_q;
        wtag    = new_tag_q;
        fill_d  = fill_q + CW'(1);
        state_d = final_q ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        idx_d   = '0;
        rd_addr = '0;
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (out_acc) begin
          if (is_last) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IW'(1);
            rd_addr = idx_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rec_i.ready = (state_q == S_IDLE);

  assign res_o.valid         = (state_q == S_SHOW);
  assign res_o.out_strength  = rd_key_q.strength;
  assign res_o.out_threat    = rd_key_q.threat;
  assign res_o.out_seen_time = rd_key_q.seen;
  assign res_o.out_tag       = rd_tag_q;
  assign res_o.run_end       = is_last;
  assign res_o.overflowed    = ovf_q;

endmodule

// ===== hdl/prs_checker.sv =====
// prs_checker: port-level assertions for the priority record sorter, and
// the bind that attaches them to the top level. Depends on the top level.
module prs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_final_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_tag_i,
  input logic [31:0] out_seen_i,
  input logic        run_end_i,
  input logic        overflowed_i
);

  // no new request is taken while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result valid");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_tag_i) && $stable(out_seen_i) && $stable(run_end_i))
    else $error("stalled result changed");

  // a record that is not final gives no result right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_final_i |=> !out_valid_i)
    else $error("result after non-final record");

  // a run keeps going and keeps its overflow flag until run_end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_end_i |=>
      out_valid_i && (overflowed_i == $past(overflowed_i)))
    else $error("run broken or overflow flag changed");

  // after the last result the sorter is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && run_end_i |=> in_ready_i)
    else $error("not ready after end of run");

endmodule

bind priority_record_sorter prs_checker u_prs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rec_i.valid),
  .in_ready_i  (rec_i.ready),
  .in_final_i  (rec_i.final_entry),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_tag_i   (res_o.out_tag),
  .out_seen_i  (res_o.out_seen_time),
  .run_end_i   (res_o.run_end),
  .overflowed_i(res_o.overflowed)
);
